[rtl/rfd_pkg.sv]
package rfd_pkg;

   // Limits of the frame size the counters are built for.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Register field widths.
   localparam int DIM_W   = 13;
   localparam int PCT_W   = 7;
   localparam int THR_W   = 8;
   localparam int CSR_W   = 13;
   localparam int CSR_IDX_W = 3;

   // Window edges can reach past the frame when a percent is above 100.
   localparam int WIN_W  = DIM_W + 2;
   localparam int PROD_W = DIM_W + PCT_W;
   localparam int NUM_W  = PROD_W - 2;
   localparam int QUO_W  = 14;

   // x / 100 is taken as (x >> 2) / 25, the last step by reciprocal and one correction.
   localparam int RCP_SHIFT = 18;
   localparam int RCP_W     = 14;
   localparam logic [RCP_W-1:0] RCP_25 = RCP_W'(((1 << RCP_SHIFT) + 24) / 25);
   localparam int CHK_W = NUM_W + 1;
   localparam logic [CHK_W-1:0] DIV_25 = CHK_W'(25);

   // Load value of the busy counter that every register write restarts; the window is ready when it runs out.
   localparam int UPD_CYCLES = 3;
   localparam int UPD_W      = 2;

   // Gray mean: sum * 683 >> 11 equals sum / 3 for any sum of three bytes.
   localparam int SUM_W      = 10;
   localparam int GRAY_MUL_W = 20;
   localparam logic [SUM_W-1:0] RCP_3 = SUM_W'(683);
   localparam int GRAY_SHIFT = 11;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_LEFT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_TOP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DIFF_THRESH  = 3'd6;

   // Register reset values.
   localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
   localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
   localparam logic [PCT_W-1:0] RST_PCT          = 7'd0;
   localparam logic [THR_W-1:0] RST_THRESHOLD    = 8'd30;

   localparam logic [7:0] FULL_RED = 8'd255;

   typedef logic [DIM_W-1:0] dim_type;
   typedef logic [WIN_W-1:0] win_pos_type;

   // Settings handed from the window unit to the pixel datapath.
   typedef struct packed {
      win_pos_type          left;
      win_pos_type          right;
      win_pos_type          top;
      win_pos_type          bottom;
      dim_type              last_col;
      dim_type              last_row;
      logic                 crop_err;
      logic [THR_W-1:0]     threshold;
      logic                 busy;
   } win_type;

endpackage

[rtl/rfd_window.sv]
module rfd_window #(
   parameter int MAX_WIDTH  = rfd_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = rfd_pkg::MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfd_pkg::CSR_W-1:0]       csr_wdata,
   output rfd_pkg::win_type                win
);

   localparam int DW = rfd_pkg::DIM_W;
   localparam int PW = rfd_pkg::PROD_W;
   localparam int NW = rfd_pkg::NUM_W;
   localparam int QW = rfd_pkg::QUO_W;
   localparam int WW = rfd_pkg::WIN_W;
   localparam int CW = rfd_pkg::CHK_W;
   localparam int MW = NW + rfd_pkg::RCP_W;

   logic [DW-1:0]                  frame_width_ff, frame_height_ff;
   logic [rfd_pkg::PCT_W-1:0]      left_pct_ff, top_pct_ff, width_pct_ff, height_pct_ff;
   logic [rfd_pkg::THR_W-1:0]      threshold_ff;
   logic [rfd_pkg::UPD_W-1:0]      busy_ff;

   logic [DW-1:0] eff_w_in, eff_h_in;
   logic [DW-1:0] eff_w1_ff, eff_h1_ff, eff_w2_ff, eff_h2_ff;
   logic          full1_ff, full2_ff;
   logic [PW-1:0] prod_in [4];
   logic [PW-1:0] prod_ff [4];
   logic [NW-1:0] num_ff  [4];
   logic [QW-1:0] quo0_in [4];
   logic [QW-1:0] quo0_ff [4];
   logic [QW-1:0] quo     [4];
   logic [MW-1:0] rcp_prod [4];
   logic [CW-1:0] chk [4];

   rfd_pkg::win_pos_type left_ff, right_ff, top_ff, bottom_ff;
   rfd_pkg::win_pos_type left_in, right_in, top_in, bottom_in;
   rfd_pkg::dim_type     last_col_ff, last_row_ff;
   logic                 crop_err_ff;

   // Register file; every write restarts the window update.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rfd_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= rfd_pkg::RST_FRAME_HEIGHT;
         left_pct_ff     <= rfd_pkg::RST_PCT;
         top_pct_ff      <= rfd_pkg::RST_PCT;
         width_pct_ff    <= rfd_pkg::RST_PCT;
         height_pct_ff   <= rfd_pkg::RST_PCT;
         threshold_ff    <= rfd_pkg::RST_THRESHOLD;
         busy_ff         <= rfd_pkg::UPD_W'(rfd_pkg::UPD_CYCLES);
      end else begin
         if (csr_we) begin
            busy_ff <= rfd_pkg::UPD_W'(rfd_pkg::UPD_CYCLES);
            unique case (csr_index)
               rfd_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[DW-1:0];
               rfd_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[DW-1:0];
               rfd_pkg::REG_CROP_LEFT:    left_pct_ff     <= csr_wdata[rfd_pkg::PCT_W-1:0];
               rfd_pkg::REG_CROP_TOP:     top_pct_ff      <= csr_wdata[rfd_pkg::PCT_W-1:0];
               rfd_pkg::REG_CROP_WIDTH:   width_pct_ff    <= csr_wdata[rfd_pkg::PCT_W-1:0];
               rfd_pkg::REG_CROP_HEIGHT:  height_pct_ff   <= csr_wdata[rfd_pkg::PCT_W-1:0];
               rfd_pkg::REG_DIFF_THRESH:  threshold_ff    <= csr_wdata[rfd_pkg::THR_W-1:0];
               default: ;
            endcase
         end else if (busy_ff != '0) begin
            busy_ff <= busy_ff - 1'b1;
         end
      end
   end

   // Stage one: clamp the frame size and form size times percent.
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w_in = DW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w_in = DW'(MAX_WIDTH);
      end else begin
         eff_w_in = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         eff_h_in = DW'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h_in = DW'(MAX_HEIGHT);
      end else begin
         eff_h_in = frame_height_ff;
      end
      prod_in[0] = PW'(eff_w_in) * PW'(left_pct_ff);
      prod_in[1] = PW'(eff_w_in) * PW'(width_pct_ff);
      prod_in[2] = PW'(eff_h_in) * PW'(top_pct_ff);
      prod_in[3] = PW'(eff_h_in) * PW'(height_pct_ff);
   end

   // Stage two: estimate of the quotient by 100, possibly one too high.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rcp_prod[i] = MW'(prod_ff[i][PW-1:2]) * MW'(rfd_pkg::RCP_25);
         quo0_in[i]  = rcp_prod[i][rfd_pkg::RCP_SHIFT +: QW];
      end
   end

   // Stage three: correct the estimate and form the window edges.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         chk[i] = CW'(quo0_ff[i]) * rfd_pkg::DIV_25;
         quo[i] = (chk[i] > CW'(num_ff[i])) ? quo0_ff[i] - 1'b1 : quo0_ff[i];
      end
      if (full2_ff) begin
         left_in   = '0;
         top_in    = '0;
         right_in  = WW'(eff_w2_ff);
         bottom_in = WW'(eff_h2_ff);
      end else begin
         left_in   = WW'(quo[0]);
         top_in    = WW'(quo[2]);
         right_in  = WW'(quo[0]) + WW'(quo[1]);
         bottom_in = WW'(quo[2]) + WW'(quo[3]);
      end
   end

   always_ff @(posedge clock) begin
      eff_w1_ff <= eff_w_in;
      eff_h1_ff <= eff_h_in;
      full1_ff  <= (width_pct_ff == '0) || (height_pct_ff == '0);
      eff_w2_ff <= eff_w1_ff;
      eff_h2_ff <= eff_h1_ff;
      full2_ff  <= full1_ff;
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= prod_in[i];
         num_ff[i]  <= prod_ff[i][PW-1:2];
         quo0_ff[i] <= quo0_in[i];
      end
      left_ff     <= left_in;
      top_ff      <= top_in;
      right_ff    <= right_in;
      bottom_ff   <= bottom_in;
      crop_err_ff <= (right_in > WW'(eff_w2_ff)) || (bottom_in > WW'(eff_h2_ff));
      last_col_ff <= eff_w2_ff - 1'b1;
      last_row_ff <= eff_h2_ff - 1'b1;
   end

   assign win.left      = left_ff;
   assign win.right     = right_ff;
   assign win.top       = top_ff;
   assign win.bottom    = bottom_ff;
   assign win.last_col  = last_col_ff;
   assign win.last_row  = last_row_ff;
   assign win.crop_err  = crop_err_ff;
   assign win.threshold = threshold_ff;
   assign win.busy      = (busy_ff != '0);

endmodule

[rtl/rfd_pixel.sv]
module rfd_pixel #(
   parameter int MAX_WIDTH  = rfd_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = rfd_pkg::MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  rfd_pkg::win_type win,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic [3:0]       rsp_tuser
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WW    = rfd_pkg::WIN_W;
   localparam int SW    = rfd_pkg::SUM_W;
   localparam int GW    = rfd_pkg::GRAY_MUL_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WW-1:0]    col_ext, row_ext;
   logic             line_end, last_in, inside_in;
   logic             accept, s1_adv;

   logic             s1_valid_ff;
   logic [47:0]      s1_pix_ff;
   logic             s1_inside_ff, s1_last_ff, s1_crop_ff;

   logic [7:0]       tr, tg, tb, rr, rg, rb;
   logic [7:0]       dr, dg, db;
   logic [SW-1:0]    sum;
   logic [GW-1:0]    gray_prod;
   logic [7:0]       gray;
   logic             mismatch;
   logic             seen_ff, seen_in;
   logic             differs;

   logic             s2_valid_ff;
   logic [7:0]       s2_red_ff, s2_green_ff, s2_blue_ff;
   logic             s2_inside_ff, s2_mismatch_ff, s2_last_ff, s2_differs_ff, s2_crop_ff;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !win.busy && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   // Raster position of the arriving item.
   always_comb begin
      col_ext   = WW'(col_ff);
      row_ext   = WW'(row_ff);
      line_end  = col_ext >= WW'(win.last_col);
      last_in   = line_end && (row_ext >= WW'(win.last_row));
      inside_in = !win.crop_err && (col_ext >= win.left) && (col_ext < win.right) &&
                  (row_ext >= win.top) && (row_ext < win.bottom);
      col_in = col_ff;
      row_in = row_ff;
      if (last_in) begin
         col_in = '0;
         row_in = '0;
      end else if (line_end) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_tdata;
         s1_inside_ff <= inside_in;
         s1_last_ff   <= last_in;
         s1_crop_ff   <= win.crop_err;
      end
   end

   // Gray mean and per-channel compare of the registered item.
   always_comb begin
      tr = s1_pix_ff[7:0];
      tg = s1_pix_ff[15:8];
      tb = s1_pix_ff[23:16];
      rr = s1_pix_ff[31:24];
      rg = s1_pix_ff[39:32];
      rb = s1_pix_ff[47:40];
      dr = abs_diff(tr, rr);
      dg = abs_diff(tg, rg);
      db = abs_diff(tb, rb);
      sum       = SW'(tr) + SW'(tg) + SW'(tb);
      gray_prod = GW'(sum) * GW'(rfd_pkg::RCP_3);
      gray      = gray_prod[rfd_pkg::GRAY_SHIFT +: 8];
      mismatch  = s1_inside_ff &&
                  ((dr > win.threshold) || (dg > win.threshold) || (db > win.threshold));
      differs   = s1_last_ff && !s1_crop_ff && (seen_ff || mismatch);
      seen_in   = s1_last_ff ? 1'b0 : (seen_ff || mismatch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            seen_ff <= seen_in;
         end
         if (!s2_valid_ff || rsp_tready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_red_ff      <= s1_inside_ff ? (mismatch ? rfd_pkg::FULL_RED : gray) : 8'd0;
         s2_green_ff    <= s1_inside_ff ? gray : 8'd0;
         s2_blue_ff     <= s1_inside_ff ? gray : 8'd0;
         s2_inside_ff   <= s1_inside_ff;
         s2_mismatch_ff <= mismatch;
         s2_last_ff     <= s1_last_ff;
         s2_differs_ff  <= differs;
         s2_crop_ff     <= s1_crop_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {s2_blue_ff, s2_green_ff, s2_red_ff};
   assign rsp_tlast  = s2_last_ff;
   assign rsp_tuser  = {s2_crop_ff, s2_differs_ff, s2_mismatch_ff, s2_inside_ff};

endmodule

[rtl/rgb_frame_diff_marker.sv]
// An accepted item passes the input register and then the result register of
// the pixel datapath before its result is shown.
// Throughput: one item per cycle while the window is not busy; rsp_tready low stalls both stages in place.
// Reset clears the raster counters and the frame mismatch flag and loads the
// register defaults; after reset and after every register write the window
// update pipeline holds req_tready low until the new window is ready.
module rgb_frame_diff_marker #(
   parameter int MAX_WIDTH  = rfd_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = rfd_pkg::MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rfd_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // test_red, test_green, test_blue, ref_red, ref_green, ref_blue
   input  logic [47:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_red, out_green, out_blue
   output logic [23:0]                   rsp_tdata,
   // frame_last
   output logic                          rsp_tlast,
   // in_window, pixel_mismatch, frame_differs, crop_error
   output logic [3:0]                    rsp_tuser
);

   rfd_pkg::win_type win;

   rfd_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .win       (win)
   );

   rfd_pixel #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pixel (
      .clock      (clock),
      .reset      (reset),
      .win        (win),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_window;
      logic       mismatch;
      logic       last;
      logic       differs;
      logic       crop_err;
   } marked_pixel_type;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [rfd_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   class frame_diff_scoreboard;
      int unsigned      frame_width, frame_height;
      int unsigned      left_pct, top_pct, width_pct, height_pct, threshold;
      int unsigned      column, row;
      int unsigned      win_left, win_top, win_right, win_bottom;
      bit               differs_seen;
      marked_pixel_type marked_q[$];
      int               errors, checked, frames_seen, inside_seen, mismatch_seen, crop_err_seen;

      function new();
         frame_width = 1920;
         frame_height = 1080;
         left_pct = 0;
         top_pct = 0;
         width_pct = 0;
         height_pct = 0;
         threshold = 30;
         column = 0;
         row = 0;
         differs_seen = 0;
         update_window();
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned max);
         if (v == 0) return 1;
         if (v > max) return max;
         return v;
      endfunction

      function void update_window();
         int unsigned w, h;
         w = clamp_dim(frame_width, rfd_pkg::MAX_WIDTH);
         h = clamp_dim(frame_height, rfd_pkg::MAX_HEIGHT);
         if (width_pct != 0 && height_pct != 0) begin
            win_left = w * left_pct / 100;
            win_top = h * top_pct / 100;
            win_right = win_left + w * width_pct / 100;
            win_bottom = win_top + h * height_pct / 100;
         end else begin
            win_left = 0;
            win_top = 0;
            win_right = w;
            win_bottom = h;
         end
      endfunction

      function void write_reg(logic [rfd_pkg::CSR_IDX_W-1:0] idx,
                              logic [rfd_pkg::CSR_W-1:0] wdata);
         case (idx)
            rfd_pkg::REG_FRAME_WIDTH:  frame_width = 32'(wdata);
            rfd_pkg::REG_FRAME_HEIGHT: frame_height = 32'(wdata);
            rfd_pkg::REG_CROP_LEFT:    left_pct = 32'(wdata[6:0]);
            rfd_pkg::REG_CROP_TOP:     top_pct = 32'(wdata[6:0]);
            rfd_pkg::REG_CROP_WIDTH:   width_pct = 32'(wdata[6:0]);
            rfd_pkg::REG_CROP_HEIGHT:  height_pct = 32'(wdata[6:0]);
            rfd_pkg::REG_DIFF_THRESH:  threshold = 32'(wdata[7:0]);
            default: return;
         endcase
         update_window();
      endfunction

      function int unsigned byte_diff(logic [7:0] a, logic [7:0] b);
         return (a > b) ? int'(a - b) : int'(b - a);
      endfunction

      function void note_pixel(logic [47:0] data);
         logic [7:0]       tr, tg, tb, rr, rg, rb;
         int unsigned      w, h, gray;
         bit               line_end;
         marked_pixel_type res;
         {rb, rg, rr, tb, tg, tr} = data;
         res = '0;
         w = clamp_dim(frame_width, rfd_pkg::MAX_WIDTH);
         h = clamp_dim(frame_height, rfd_pkg::MAX_HEIGHT);
         res.crop_err = win_right > w || win_bottom > h;
         res.in_window = !res.crop_err && column >= win_left && column < win_right &&
                         row >= win_top && row < win_bottom;
         line_end = column >= w - 1;
         res.last = line_end && row >= h - 1;
         if (res.in_window) begin
            gray = (int'(tr) + int'(tg) + int'(tb)) / 3;
            res.mismatch = byte_diff(tr, rr) > threshold || byte_diff(tg, rg) > threshold ||
                           byte_diff(tb, rb) > threshold;
            res.red = res.mismatch ? rfd_pkg::FULL_RED : 8'(gray);
            res.green = 8'(gray);
            res.blue = 8'(gray);
         end
         if (res.last) begin
            res.differs = !res.crop_err && (differs_seen || res.mismatch);
            differs_seen = 0;
            column = 0;
            row = 0;
            frames_seen++;
         end else begin
            differs_seen = differs_seen || res.mismatch;
            if (line_end) begin
               column = 0;
               row = row + 1;
            end else begin
               column = column + 1;
            end
         end
         inside_seen += int'(res.in_window);
         mismatch_seen += int'(res.mismatch);
         crop_err_seen += int'(res.crop_err);
         marked_q.push_back(res);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [23:0] tdata, logic tlast, logic [3:0] tuser);
         marked_pixel_type want;
         if (marked_q.size() == 0) begin
            $error("result item with no pixel pending: tdata=%h", tdata);
            errors++;
            return;
         end
         want = marked_q.pop_front();
         checked++;
         compare_field("out_red", want.red, tdata[7:0]);
         compare_field("out_green", want.green, tdata[15:8]);
         compare_field("out_blue", want.blue, tdata[23:16]);
         compare_field("in_window", 8'(want.in_window), 8'(tuser[0]));
         compare_field("pixel_mismatch", 8'(want.mismatch), 8'(tuser[1]));
         compare_field("frame_differs", 8'(want.differs), 8'(tuser[2]));
         compare_field("crop_error", 8'(want.crop_err), 8'(tuser[3]));
         compare_field("frame_last", 8'(want.last), 8'(tlast));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [rfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rfd_pkg::CSR_W-1:0]     csr_wdata = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [47:0]                   req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;
   logic                          rsp_tlast;
   logic [3:0]                    rsp_tuser;

   frame_diff_scoreboard board;
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   int pixels_sent = 0;
   int phases_run = 0;

   rgb_frame_diff_marker dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic logic [47:0] pixel_pair(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                                              logic [7:0] rr, logic [7:0] rg, logic [7:0] rb);
      return {rb, rg, rr, tb, tg, tr};
   endfunction

   // Half the pairs sit near the threshold so both sides of the compare get hit.
   function automatic logic [47:0] random_pair(int unsigned thr);
      logic [7:0] t [3];
      logic [7:0] r [3];
      int         kind, d, v;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         t[i] = 8'($urandom);
         if (kind < 5) begin
            d = int'($urandom_range(0, 2 * thr + 4)) - int'(thr + 2);
            v = int'(t[i]) + d;
            r[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
         end else if (kind < 7) begin
            r[i] = t[i];
         end else if (kind == 7) begin
            t[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            r[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end else begin
            r[i] = 8'($urandom);
         end
      end
      return {r[2], r[1], r[0], t[2], t[1], t[0]};
   endfunction

   task automatic send_pixel(input logic [47:0] data);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = data;
      do @(posedge clock); while (!req_tready);
      board.note_pixel(data);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.marked_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [rfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rfd_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic program_frame(input logic [12:0] w, input logic [12:0] h,
                                input logic [12:0] l, input logic [12:0] t,
                                input logic [12:0] cw, input logic [12:0] ch,
                                input logic [12:0] thr);
      write_csr(rfd_pkg::REG_FRAME_WIDTH, w);
      write_csr(rfd_pkg::REG_FRAME_HEIGHT, h);
      write_csr(rfd_pkg::REG_CROP_LEFT, l);
      write_csr(rfd_pkg::REG_CROP_TOP, t);
      write_csr(rfd_pkg::REG_CROP_WIDTH, cw);
      write_csr(rfd_pkg::REG_CROP_HEIGHT, ch);
      write_csr(rfd_pkg::REG_DIFF_THRESH, thr);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Percent registers are 7 bits wide; now and then junk rides in the upper bits.
   function automatic logic [12:0] pct_word(int unsigned pct);
      if ($urandom_range(0, 3) == 0) return {6'($urandom), 7'(pct)};
      return 13'(pct);
   endfunction

   task automatic random_phase(output int items);
      int unsigned w, h, l, t, cw, ch, thr;
      int          kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         case ($urandom_range(0, 3))
            0: w = 4096;
            1: w = 8191;
            2: w = $urandom_range(100, 4095);
            default: w = $urandom_range(4097, 8190);
         endcase
         h = $urandom_range(1, 3);
         if ($urandom_range(0, 1)) begin
            h = w;
            w = $urandom_range(1, 4);
         end
         items = 20;
      end else begin
         w = (kind == 1) ? 0 : $urandom_range(1, 12);
         h = (kind == 2) ? 0 : $urandom_range(1, 6);
         items = $urandom_range(10, 45);
      end
      case ($urandom_range(0, 9))
         6: begin
            l = $urandom_range(0, 127);
            t = $urandom_range(0, 127);
            cw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 127);
            ch = (cw != 0) ? 0 : $urandom_range(0, 127);
         end
         7: begin
            l = $urandom_range(30, 100);
            t = $urandom_range(0, 50);
            cw = $urandom_range(101 - l, 127);
            ch = $urandom_range(1, 100 - t);
            if ($urandom_range(0, 1)) begin
               {l, t} = {t, l};
               {cw, ch} = {ch, cw};
            end
         end
         8: begin
            l = $urandom_range(0, 127);
            t = $urandom_range(0, 127);
            cw = $urandom_range(0, 127);
            ch = $urandom_range(0, 127);
         end
         9: begin
            l = 0;
            t = 0;
            cw = 100;
            ch = 100;
         end
         default: begin
            l = $urandom_range(0, 70);
            t = $urandom_range(0, 70);
            cw = $urandom_range(1, 100 - l);
            ch = $urandom_range(1, 100 - t);
         end
      endcase
      case ($urandom_range(0, 9))
         0: thr = 0;
         1: thr = 255;
         default: thr = $urandom_range(0, 80);
      endcase
      program_frame(13'(w), 13'(h), pct_word(l), pct_word(t), pct_word(cw), pct_word(ch),
                    ($urandom_range(0, 3) == 0) ? {5'($urandom), 8'(thr)} : 13'(thr));
   endtask

   // Result side: random backpressure plus one long hold when asked for.
   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            repeat (120) begin
               @(negedge clock);
               rsp_tready = 1'b0;
            end
         end
         gap = idle_on ? $urandom_range(0, 9) : 0;
         repeat (gap) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   initial begin
      int items;
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Power-up settings: full 1920x1080 window, threshold 30.
      send_pixel(pixel_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      send_pixel(pixel_pair(8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_pixel(pixel_pair(8'd0, 8'd100, 8'd0, 8'd0, 8'd131, 8'd0));
      send_pixel(pixel_pair(8'd0, 8'd0, 8'd200, 8'd0, 8'd0, 8'd231));
      send_pixel(pixel_pair(8'd2, 8'd2, 8'd1, 8'd2, 8'd2, 8'd1));
      wait_drained();

      // Tiny frame, zero threshold; the counters were mid-line when the size shrank.
      program_frame(13'd2, 13'd2, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
      send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd10, 8'd20, 8'd30));
      send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd10, 8'd21, 8'd30));
      send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd10, 8'd20, 8'd30));
      send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd10, 8'd20, 8'd30));
      wait_drained();

      // Right half of the top line only; a threshold of 255 can never trip.
      program_frame(13'd4, 13'd2, 13'd50, 13'd0, 13'd50, 13'd50, 13'd255);
      repeat (4) send_pixel(pixel_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
      wait_drained();

      // Window runs past the right edge of the frame.
      program_frame(13'd10, 13'd4, 13'd60, 13'd0, 13'd50, 13'd100, 13'd0);
      repeat (3) send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      wait_drained();

      // Width percent rounds down to no pixels at all.
      program_frame(13'd5, 13'd3, 13'd0, 13'd0, 13'd10, 13'd50, 13'd0);
      repeat (3) send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      wait_drained();

      // Zero frame size acts as one pixel; the unused index must not disturb anything.
      write_csr(REG_UNUSED, 13'h1fff);
      program_frame(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd30);
      send_pixel(pixel_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
      send_pixel(pixel_pair(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
      wait_drained();

      while (pixels_sent < 820) begin
         random_phase(items);
         phases_run++;
         idle_on = ($urandom_range(0, 3) != 0);
         if (phases_run == 6) begin
            // Long result stall with the input pushing back-to-back.
            idle_on = 1'b0;
            long_hold_req = 1'b1;
            items = 40;
         end
         repeat (items) send_pixel(random_pair(board.threshold));
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d pixel results in %0d setting phases, %0d frame ends.",
               board.checked, phases_run, board.frames_seen);
      $display("%0d pixels fell inside the window, %0d mismatched, %0d carried a crop error.",
               board.inside_seen, board.mismatch_seen, board.crop_err_seen);
      if (board.errors == 0 && board.marked_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
